// ----- hw/rtl/clp_pkg.sv -----
// Package for the color blend and palette match block.
// Holds widths, the fixed palette, the search candidate type and its
// compare function. No dependencies.
package clp_pkg;

  localparam int CH_W            = 8;
  localparam int PROG_W          = 9;
  localparam int IDX_W           = 5;
  localparam int DIST_W          = 18;
  localparam int TABLE_SIZE      = 32;
  localparam int PALETTE_ENTRIES = 32;
  localparam int NUM_SEARCH      = (PALETTE_ENTRIES > TABLE_SIZE) ? TABLE_SIZE :
                                   (PALETTE_ENTRIES < 1) ? 1 : PALETTE_ENTRIES;
  localparam int PIPE_DEPTH      = 5;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  localparam rgb_t PALETTE [TABLE_SIZE] = '{
    '{8'd0,   8'd0,   8'd0  }, '{8'd29,  8'd43,  8'd83 },
    '{8'd126, 8'd37,  8'd83 }, '{8'd0,   8'd135, 8'd81 },
    '{8'd171, 8'd82,  8'd54 }, '{8'd95,  8'd87,  8'd79 },
    '{8'd194, 8'd195, 8'd199}, '{8'd255, 8'd241, 8'd232},
    '{8'd255, 8'd0,   8'd77 }, '{8'd255, 8'd163, 8'd0  },
    '{8'd255, 8'd236, 8'd39 }, '{8'd0,   8'd228, 8'd54 },
    '{8'd41,  8'd173, 8'd255}, '{8'd131, 8'd118, 8'd156},
    '{8'd255, 8'd119, 8'd168}, '{8'd255, 8'd204, 8'd170},
    '{8'd41,  8'd24,  8'd20 }, '{8'd17,  8'd29,  8'd53 },
    '{8'd66,  8'd33,  8'd59 }, '{8'd18,  8'd83,  8'd89 },
    '{8'd116, 8'd47,  8'd41 }, '{8'd73,  8'd51,  8'd59 },
    '{8'd162, 8'd136, 8'd121}, '{8'd243, 8'd239, 8'd125},
    '{8'd190, 8'd18,  8'd80 }, '{8'd255, 8'd108, 8'd36 },
    '{8'd168, 8'd231, 8'd46 }, '{8'd0,   8'd181, 8'd67 },
    '{8'd6,   8'd90,  8'd181}, '{8'd117, 8'd70,  8'd101},
    '{8'd255, 8'd110, 8'd89 }, '{8'd255, 8'd157, 8'd129}
  };

  // Lower index sits in a; b wins only on a strictly smaller distance.
  function automatic cand_t cand_pick(input cand_t a, input cand_t b);
    return (b.dist_sq < a.dist_sq) ? b : a;
  endfunction

endpackage

// ----- hw/rtl/clp_blend.sv -----
// One channel of the linear blend: start + trunc((end - start) * p / 256),
// progress saturated at 1.0 and result clamped to a byte. Uses clp_pkg.
module clp_blend
  import clp_pkg::*;
(
  input  logic [CH_W-1:0]   start_ch,
  input  logic [CH_W-1:0]   end_ch,
  input  logic [PROG_W-1:0] progress,
  output logic [CH_W-1:0]   blend_ch
);

  logic [PROG_W-1:0]  p_sat;
  logic signed [8:0]  diff;
  logic signed [18:0] prod;
  logic signed [18:0] prod_adj;
  logic signed [10:0] step;
  logic signed [11:0] sum;

  always_comb begin
    // anything with the top bit set is at or above 1.0
    p_sat    = progress[PROG_W-1] ? 9'd256 : progress;
    diff     = $signed({1'b0, end_ch}) - $signed({1'b0, start_ch});
    prod     = diff * $signed({1'b0, p_sat});
    // bias negatives so the shift truncates toward zero
    prod_adj = prod + (prod[18] ? 19'sd255 : 19'sd0);
    step     = prod_adj[18:8];
    sum      = $signed({4'b0000, start_ch}) + $signed({step[10], step});
    if (sum[11]) begin
      blend_ch = '0;
    end else if (sum[10:8] != 3'b000) begin
      blend_ch = '1;
    end else begin
      blend_ch = sum[7:0];
    end
  end

endmodule

// ----- hw/rtl/clp_search.sv -----
// Nearest palette entry search: squared RGB distance to every entry, then a
// registered compare tree, lowest index on ties. Three register stages.
// Uses clp_pkg.
module clp_search
  import clp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             color_valid,
  input  rgb_t             color,
  output logic             match_valid,
  output rgb_t             match_color,
  output logic [IDX_W-1:0] match_index
);

  cand_t dist_nxt [TABLE_SIZE];
  cand_t dist_r   [TABLE_SIZE];
  cand_t lvl1     [TABLE_SIZE/2];
  cand_t lvl2     [TABLE_SIZE/4];
  cand_t quad_nxt [TABLE_SIZE/8];
  cand_t quad_r   [TABLE_SIZE/8];
  cand_t half     [2];
  cand_t best;
  logic  dist_valid_r;
  logic  quad_valid_r;
  logic  match_valid_r;
  rgb_t  match_color_r;
  logic [IDX_W-1:0] match_index_r;

  function automatic logic [15:0] sq_abs(input logic [CH_W-1:0] a,
                                         input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // distances; entries past the search limit get a distance no entry reaches
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      dist_nxt[i].idx = IDX_W'(i);
      if (i < NUM_SEARCH) begin
        dist_nxt[i].dist_sq = DIST_W'(sq_abs(color.red,   PALETTE[i].red))
                            + DIST_W'(sq_abs(color.green, PALETTE[i].green))
                            + DIST_W'(sq_abs(color.blue,  PALETTE[i].blue));
      end else begin
        dist_nxt[i].dist_sq = '1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_SIZE/2; i++) begin
      lvl1[i] = cand_pick(dist_r[2*i], dist_r[2*i+1]);
    end
    for (int i = 0; i < TABLE_SIZE/4; i++) begin
      lvl2[i] = cand_pick(lvl1[2*i], lvl1[2*i+1]);
    end
    for (int i = 0; i < TABLE_SIZE/8; i++) begin
      quad_nxt[i] = cand_pick(lvl2[2*i], lvl2[2*i+1]);
    end
  end

  always_comb begin
    half[0] = cand_pick(quad_r[0], quad_r[1]);
    half[1] = cand_pick(quad_r[2], quad_r[3]);
    best    = cand_pick(half[0], half[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_valid_r  <= 1'b0;
      quad_valid_r  <= 1'b0;
      match_valid_r <= 1'b0;
    end else begin
      dist_valid_r  <= color_valid;
      quad_valid_r  <= dist_valid_r;
      match_valid_r <= quad_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    dist_r        <= dist_nxt;
    quad_r        <= quad_nxt;
    match_index_r <= best.idx;
    match_color_r <= PALETTE[best.idx];
  end

  assign match_valid = match_valid_r;
  assign match_color = match_color_r;
  assign match_index = match_index_r;

  a_tree_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    quad_valid_r |-> ({1'b0, quad_r[0].idx} < (IDX_W+1)'(NUM_SEARCH)))
    else $error("search tree picked an entry beyond the search limit");

  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    match_valid_r |-> $past(dist_valid_r, 2))
    else $error("match strobe without a distance stage behind it");

  a_color_follows_index: assert property (@(posedge clk) disable iff (!rst_n)
    match_valid_r |-> (match_color_r == PALETTE[match_index_r]))
    else $error("matched color does not belong to matched index");

endmodule

// ----- hw/rtl/color_lerp_palette_quantizer.sv -----
// Top level of the color blend and palette match block.
// Depends on clp_pkg, clp_blend and clp_search.
//
// A request is taken on every clock where start is high; busy stays low, so
// one pixel can enter each cycle. Each result is strobed on out_valid for a
// single cycle, in request order, after passing through an input register,
// the blend multiply, the 32 distance units, and two stages of the compare
// tree, each of them registered. The receiver cannot stall the
// pipeline and must take each result on the cycle it is strobed.
module color_lerp_palette_quantizer
  import clp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CH_W-1:0]   in_start_red,
  input  logic [CH_W-1:0]   in_start_green,
  input  logic [CH_W-1:0]   in_start_blue,
  input  logic [CH_W-1:0]   in_end_red,
  input  logic [CH_W-1:0]   in_end_green,
  input  logic [CH_W-1:0]   in_end_blue,
  input  logic [PROG_W-1:0] in_progress,
  output logic              out_valid,
  output logic [CH_W-1:0]   out_match_red,
  output logic [CH_W-1:0]   out_match_green,
  output logic [CH_W-1:0]   out_match_blue,
  output logic [IDX_W-1:0]  out_match_index
);

  logic              req_valid_r;
  rgb_t              start_r;
  rgb_t              end_r;
  logic [PROG_W-1:0] progress_r;
  rgb_t              blend_nxt;
  rgb_t              blend_r;
  logic              blend_valid_r;
  rgb_t              match_color;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      blend_valid_r <= 1'b0;
    end else begin
      req_valid_r   <= start && !busy;
      blend_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    start_r    <= '{in_start_red, in_start_green, in_start_blue};
    end_r      <= '{in_end_red, in_end_green, in_end_blue};
    progress_r <= in_progress;
    blend_r    <= blend_nxt;
  end

  clp_blend u_blend_red (
    .start_ch (start_r.red),
    .end_ch   (end_r.red),
    .progress (progress_r),
    .blend_ch (blend_nxt.red)
  );

  clp_blend u_blend_green (
    .start_ch (start_r.green),
    .end_ch   (end_r.green),
    .progress (progress_r),
    .blend_ch (blend_nxt.green)
  );

  clp_blend u_blend_blue (
    .start_ch (start_r.blue),
    .end_ch   (end_r.blue),
    .progress (progress_r),
    .blend_ch (blend_nxt.blue)
  );

  clp_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .color_valid (blend_valid_r),
    .color       (blend_r),
    .match_valid (out_valid),
    .match_color (match_color),
    .match_index (out_match_index)
  );

  assign out_match_red   = match_color.red;
  assign out_match_green = match_color.green;
  assign out_match_blue  = match_color.blue;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_DEPTH))
    else $error("result strobe without a request five cycles earlier");

  a_full_progress_hits_end: assert property (@(posedge clk) disable iff (!rst_n)
    blend_valid_r && $past(progress_r[PROG_W-1]) |-> (blend_r == $past(end_r)))
    else $error("saturated progress did not yield the end color");

  a_zero_progress_keeps_start: assert property (@(posedge clk) disable iff (!rst_n)
    blend_valid_r && ($past(progress_r) == '0) |-> (blend_r == $past(start_r)))
    else $error("zero progress moved away from the start color");

endmodule

// ----- test/tb.sv -----
// Testbench for color_lerp_palette_quantizer: drives blend requests, predicts
// the nearest palette match locally and checks every strobed result in order.
// Depends on clp_pkg and the block's RTL.
module tb;
  import clp_pkg::*;

  localparam int CYCLE_LIMIT = 250000;
  localparam int RAND_ITEMS  = 1930;
  localparam int QUIET_TAIL  = 250;
  localparam int Q8_UNITY    = 256;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    rgb_t              from_c;
    rgb_t              to_c;
    logic [PROG_W-1:0] prog;
    int                gap;
    bit                drain;
  } lerp_req_t;

  typedef struct {
    rgb_t             color;
    logic [IDX_W-1:0] idx;
    bit               tie;
  } swatch_t;

  localparam rgb_t SWATCH [32] = '{
    '{8'd0,   8'd0,   8'd0  }, '{8'd29,  8'd43,  8'd83 },
    '{8'd126, 8'd37,  8'd83 }, '{8'd0,   8'd135, 8'd81 },
    '{8'd171, 8'd82,  8'd54 }, '{8'd95,  8'd87,  8'd79 },
    '{8'd194, 8'd195, 8'd199}, '{8'd255, 8'd241, 8'd232},
    '{8'd255, 8'd0,   8'd77 }, '{8'd255, 8'd163, 8'd0  },
    '{8'd255, 8'd236, 8'd39 }, '{8'd0,   8'd228, 8'd54 },
    '{8'd41,  8'd173, 8'd255}, '{8'd131, 8'd118, 8'd156},
    '{8'd255, 8'd119, 8'd168}, '{8'd255, 8'd204, 8'd170},
    '{8'd41,  8'd24,  8'd20 }, '{8'd17,  8'd29,  8'd53 },
    '{8'd66,  8'd33,  8'd59 }, '{8'd18,  8'd83,  8'd89 },
    '{8'd116, 8'd47,  8'd41 }, '{8'd73,  8'd51,  8'd59 },
    '{8'd162, 8'd136, 8'd121}, '{8'd243, 8'd239, 8'd125},
    '{8'd190, 8'd18,  8'd80 }, '{8'd255, 8'd108, 8'd36 },
    '{8'd168, 8'd231, 8'd46 }, '{8'd0,   8'd181, 8'd67 },
    '{8'd6,   8'd90,  8'd181}, '{8'd117, 8'd70,  8'd101},
    '{8'd255, 8'd110, 8'd89 }, '{8'd255, 8'd157, 8'd129}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CH_W-1:0]   in_start_red = '0;
  logic [CH_W-1:0]   in_start_green = '0;
  logic [CH_W-1:0]   in_start_blue = '0;
  logic [CH_W-1:0]   in_end_red = '0;
  logic [CH_W-1:0]   in_end_green = '0;
  logic [CH_W-1:0]   in_end_blue = '0;
  logic [PROG_W-1:0] in_progress = '0;
  logic              out_valid;
  logic [CH_W-1:0]   out_match_red;
  logic [CH_W-1:0]   out_match_green;
  logic [CH_W-1:0]   out_match_blue;
  logic [IDX_W-1:0]  out_match_index;

  lerp_req_t lerp_q[$];
  swatch_t   swatch_q[$];

  bit took_req;
  int gap_left = -1;
  int mismatches = 0;
  int accepted = 0;
  int checked = 0;
  int n_full = 0;
  int n_bare = 0;
  int n_ties = 0;
  int cycles = 0;
  int total_items = 0;

  color_lerp_palette_quantizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_start_red    (in_start_red),
    .in_start_green  (in_start_green),
    .in_start_blue   (in_start_blue),
    .in_end_red      (in_end_red),
    .in_end_green    (in_end_green),
    .in_end_blue     (in_end_blue),
    .in_progress     (in_progress),
    .out_valid       (out_valid),
    .out_match_red   (out_match_red),
    .out_match_green (out_match_green),
    .out_match_blue  (out_match_blue),
    .out_match_index (out_match_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // start + trunc((end - start) * progress / 256), progress saturated at 1.0
  function automatic logic [CH_W-1:0] blend_byte(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [PROG_W-1:0] p);
    int frac;
    int mix;
    frac = (p > Q8_UNITY) ? Q8_UNITY : int'(p);
    mix = int'(a) + ((int'(b) - int'(a)) * frac) / Q8_UNITY;
    if (mix < 0) mix = 0;
    if (mix > 255) mix = 255;
    return mix[CH_W-1:0];
  endfunction

  function automatic swatch_t nearest_swatch(input rgb_t from_c, input rgb_t to_c,
                                             input logic [PROG_W-1:0] prog);
    rgb_t    mixc;
    int      dr;
    int      dg;
    int      db;
    int      sq;
    int      best_sq;
    int      n;
    swatch_t res;
    mixc.red   = blend_byte(from_c.red, to_c.red, prog);
    mixc.green = blend_byte(from_c.green, to_c.green, prog);
    mixc.blue  = blend_byte(from_c.blue, to_c.blue, prog);
    n = PALETTE_ENTRIES;
    if (n > 32) n = 32;
    if (n < 1) n = 1;
    best_sq = 0;
    res.idx = '0;
    res.tie = 1'b0;
    for (int i = 0; i < n; i++) begin
      dr = int'(mixc.red) - int'(SWATCH[i].red);
      dg = int'(mixc.green) - int'(SWATCH[i].green);
      db = int'(mixc.blue) - int'(SWATCH[i].blue);
      sq = dr * dr + dg * dg + db * db;
      // only a strictly closer entry replaces the lower index
      if (i == 0 || sq < best_sq) begin
        best_sq = sq;
        res.idx = IDX_W'(i);
        res.tie = 1'b0;
      end else if (sq == best_sq) begin
        res.tie = 1'b1;
      end
    end
    res.color = SWATCH[res.idx];
    return res;
  endfunction

  function automatic logic [CH_W-1:0] near_byte(input logic [CH_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 12)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  function automatic rgb_t pick_color();
    rgb_t c;
    int   sel;
    int   k;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      c.red   = CH_W'($urandom_range(0, 255));
      c.green = CH_W'($urandom_range(0, 255));
      c.blue  = CH_W'($urandom_range(0, 255));
    end else if (sel < 85) begin
      // land near a palette entry to stress the decision boundaries
      k = $urandom_range(0, 31);
      c.red   = near_byte(SWATCH[k].red);
      c.green = near_byte(SWATCH[k].green);
      c.blue  = near_byte(SWATCH[k].blue);
    end else begin
      c.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      c.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      c.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return c;
  endfunction

  function automatic logic [PROG_W-1:0] pick_prog();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return PROG_W'($urandom_range(0, 256));
    if (sel < 50) return '0;
    if (sel < 65) return PROG_W'(Q8_UNITY);
    if (sel < 80) return PROG_W'($urandom_range(257, 511));
    return PROG_W'($urandom_range(0, 16));
  endfunction

  task automatic add_req(input rgb_t from_c, input rgb_t to_c,
                         input logic [PROG_W-1:0] prog, input int gap, input bit drain);
    lerp_req_t r;
    r.from_c = from_c;
    r.to_c   = to_c;
    r.prog   = prog;
    r.gap    = gap;
    r.drain  = drain;
    lerp_q.push_back(r);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("cycle %0d: mismatch: %s", cycles, msg);
  endtask

  // Sender: hold a request until taken, serve its gap, optionally drain first.
  always @(negedge clk) begin
    lerp_req_t r;
    bit        go;
    if (rst_n && !(start && !took_req)) begin
      go = 1'b0;
      if (lerp_q.size() != 0) begin
        if (gap_left < 0) gap_left = lerp_q[0].gap;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(lerp_q[0].drain && swatch_q.size() != 0)) begin
          r = lerp_q.pop_front();
          gap_left = -1;
          go = 1'b1;
          in_start_red   <= r.from_c.red;
          in_start_green <= r.from_c.green;
          in_start_blue  <= r.from_c.blue;
          in_end_red     <= r.to_c.red;
          in_end_green   <= r.to_c.green;
          in_end_blue    <= r.to_c.blue;
          in_progress    <= r.prog;
        end
      end
      if (!go) begin
        // scramble the fields while no request is offered
        in_start_red   <= CH_W'($urandom_range(0, 255));
        in_start_green <= CH_W'($urandom_range(0, 255));
        in_start_blue  <= CH_W'($urandom_range(0, 255));
        in_end_red     <= CH_W'($urandom_range(0, 255));
        in_end_green   <= CH_W'($urandom_range(0, 255));
        in_end_blue    <= CH_W'($urandom_range(0, 255));
        in_progress    <= PROG_W'($urandom_range(0, 511));
      end
      start <= go;
    end
  end

  // Receiver: check strobed results, then record the request taken this edge.
  always @(posedge clk) begin
    swatch_t want;
    took_req = rst_n && start && !busy;
    if (rst_n && out_valid !== 1'b0) begin
      if (swatch_q.size() == 0) begin
        flag_mismatch("result strobed with no request pending");
      end else begin
        want = swatch_q.pop_front();
        checked++;
        if (out_match_index !== want.idx)
          flag_mismatch($sformatf("index got %0d want %0d", out_match_index, want.idx));
        if (out_match_red !== want.color.red)
          flag_mismatch($sformatf("red got %0d want %0d", out_match_red, want.color.red));
        if (out_match_green !== want.color.green)
          flag_mismatch($sformatf("green got %0d want %0d", out_match_green,
                                  want.color.green));
        if (out_match_blue !== want.color.blue)
          flag_mismatch($sformatf("blue got %0d want %0d", out_match_blue, want.color.blue));
      end
    end
    if (took_req) begin
      want = nearest_swatch({in_start_red, in_start_green, in_start_blue},
                            {in_end_red, in_end_green, in_end_blue}, in_progress);
      swatch_q.push_back(want);
      accepted++;
      if (in_progress >= Q8_UNITY) n_full++;
      if (in_progress == 0) n_bare++;
      if (want.tie) n_ties++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles: %0d of %0d requests taken, %0d results pending",
               cycles, accepted, total_items, swatch_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rgb_t    c;
    swatch_t m;
    int      ties_found;
    int      pct;
    int      gap;
    ties_found = 0;

    add_req({8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd0}, 9'd0, 0, 1'b0);
    add_req({8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255}, 9'd256, 0, 1'b0);
    add_req({8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, 9'd256, 0, 1'b0);
    add_req({8'd255, 8'd255, 8'd255}, {8'd0, 8'd0, 8'd0}, 9'd256, 0, 1'b0);
    // saturated progress
    add_req({8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, 9'd511, 0, 1'b0);
    add_req({8'd255, 8'd255, 8'd255}, {8'd0, 8'd0, 8'd0}, 9'd257, 0, 1'b0);
    // negative step truncates toward zero, not down
    add_req({8'd255, 8'd255, 8'd255}, {8'd0, 8'd0, 8'd0}, 9'd1, 0, 1'b0);
    add_req({8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, 9'd1, 0, 1'b0);
    add_req({8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, 9'd128, 0, 1'b0);
    add_req({8'd200, 8'd10, 8'd90}, {8'd10, 8'd200, 8'd90}, 9'd128, 3, 1'b0);
    add_req({8'd255, 8'd0, 8'd128}, {8'd0, 8'd255, 8'd128}, 9'd255, 0, 1'b0);
    // bare matches on exact palette colors
    add_req({8'd194, 8'd195, 8'd199}, {8'd0, 8'd0, 8'd0}, 9'd0, 0, 1'b0);
    add_req({8'd41, 8'd173, 8'd255}, {8'd255, 8'd255, 8'd255}, 9'd0, 0, 1'b0);
    add_req({8'd255, 8'd157, 8'd129}, {8'd0, 8'd0, 8'd0}, 9'd0, 0, 1'b0);
    add_req({8'd12, 8'd34, 8'd56}, {8'd255, 8'd119, 8'd168}, 9'd256, 0, 1'b0);
    add_req({8'd170, 8'd85, 8'd170}, {8'd85, 8'd170, 8'd85}, 9'd384, 0, 1'b0);
    add_req({8'd1, 8'd2, 8'd4}, {8'd254, 8'd253, 8'd251}, 9'd255, 0, 1'b0);
    add_req({8'd100, 8'd100, 8'd100}, {8'd100, 8'd100, 8'd100}, 9'd200, 0, 1'b0);
    add_req({8'd128, 8'd64, 8'd32}, {8'd32, 8'd64, 8'd128}, 9'd256, 5, 1'b0);

    // hunt for colors equidistant from two palette entries
    for (int k = 0; k < 300000 && ties_found < 4; k++) begin
      c = pick_color();
      m = nearest_swatch(c, c, '0);
      if (m.tie) begin
        add_req(c, pick_color(), 9'd0, 0, 1'b0);
        ties_found++;
      end
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ((i / 160) % 4)
        0: pct = 0;
        1: pct = 12;
        2: pct = 40;
        default: pct = 4;
      endcase
      if (i >= RAND_ITEMS - QUIET_TAIL) pct = 0;
      gap = ($urandom_range(0, 99) < pct) ? $urandom_range(1, 18) : 0;
      add_req(pick_color(), pick_color(), pick_prog(), gap,
              (i % 480 == 0) && (i < RAND_ITEMS - QUIET_TAIL));
    end
    total_items = lerp_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted != total_items) @(posedge clk);
    while (swatch_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);

    $display("Covered %0d blend requests: %0d at full or saturated progress, %0d bare matches,",
             accepted, n_full, n_bare);
    $display("%0d equal-distance picks; %0d results compared, %0d mismatches.",
             n_ties, checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
